[design/bbst_pkg.sv]
// Shared types and constants for the bad-block skip translation core.
// No dependencies; imported by bbst_ctrl and the core top in the design folder.
package bbst_pkg;

    // Default sizing of the NAND array and the locked list
    localparam int BLOCK_COUNT_DEF = 4096;
    localparam int OFFSET_BITS_DEF = 17;
    localparam int LOCKED_MAX_DEF  = 2048;

    // Fixed field widths
    localparam int MODE_W = 2;
    localparam int LBLK_W = 12;
    localparam int HDR_W  = 32;
    localparam int ADDR_W = 29;
    localparam int STAT_W = 2;
    localparam int GOOD_W = 13;

    // Expected header magic for a table build
    localparam logic [HDR_W-1:0] HEADER_MAGIC = 32'h0058_4642;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_XLATE  = 2'd2
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_MAGIC = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_XLATE
    } state_t;

    // Request word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LBLK_W-1:0] locked_block;
        logic [HDR_W-1:0]  header_word;
        logic [ADDR_W-1:0] vaddr;
    } req_t;

    // Response word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] physical_address;
        logic [GOOD_W-1:0] good_count;
    } rsp_t;

endpackage

[design/bbst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bbst_ctrl.sv]
// Sequencer for list appends, the table build walk and address translation.
// Depends on bbst_pkg; drives the locked-list RAM and the remap-table RAM.
module bbst_ctrl
    import bbst_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LOCKED_MAX  = LOCKED_MAX_DEF,
    localparam int BLK_W = $clog2(BLOCK_COUNT),
    localparam int LI_W  = (LOCKED_MAX > 1) ? $clog2(LOCKED_MAX) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    // response channel
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    // locked-list RAM
    output logic             list_we,
    output logic [LI_W-1:0]  list_waddr,
    output logic [LBLK_W-1:0] list_wdata,
    output logic [LI_W-1:0]  list_raddr,
    input  logic [LBLK_W-1:0] list_rdata,
    // remap-table RAM
    output logic             map_we,
    output logic [BLK_W-1:0] map_waddr,
    output logic [BLK_W-1:0] map_wdata,
    output logic [BLK_W-1:0] map_raddr,
    input  logic [BLK_W-1:0] map_rdata
);

    localparam int UW    = $clog2(BLOCK_COUNT + 1);
    localparam int LC_W  = $clog2(LOCKED_MAX + 1);
    localparam int VB_W  = ADDR_W - OFFSET_BITS;
    localparam int CMP_W = (LBLK_W > BLK_W) ? LBLK_W : BLK_W;
    localparam int VC_W  = (VB_W > UW) ? VB_W : UW;
    localparam int PW    = (ADDR_W > BLK_W + OFFSET_BITS) ? ADDR_W : BLK_W + OFFSET_BITS;

    state_t                 state_reg, state_next;
    logic [LC_W-1:0]        lcount_reg, lcount_next;
    logic [UW-1:0]          usable_reg, usable_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [LC_W-1:0]        ptr_reg, ptr_next;
    logic [UW-1:0]          good_reg, good_next;
    logic [OFFSET_BITS-1:0] xoff_reg, xoff_next;
    logic                   xrange_reg, xrange_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   out_free;
    logic [VB_W-1:0]        vblk;
    logic [OFFSET_BITS-1:0] voff;
    logic [LC_W-1:0]        ptr_inc;
    logic [UW-1:0]          good_inc;
    logic                   match;
    logic [PW-1:0]          phys_wide;

    // Address split and walk helpers
    assign vblk      = req.vaddr[ADDR_W-1:OFFSET_BITS];
    assign voff      = req.vaddr[OFFSET_BITS-1:0];
    assign ptr_inc   = ptr_reg + 1'b1;
    assign good_inc  = good_reg + 1'b1;
    assign match     = (ptr_reg < lcount_reg) &&
                       (CMP_W'(list_rdata) == CMP_W'(blk_reg));
    assign phys_wide = (PW'(map_rdata) << OFFSET_BITS) | PW'(xoff_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lcount_reg    <= '0;
            usable_reg    <= '0;
            blk_reg       <= '0;
            ptr_reg       <= '0;
            good_reg      <= '0;
            xrange_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcount_reg    <= lcount_next;
            usable_reg    <= usable_next;
            blk_reg       <= blk_next;
            ptr_reg       <= ptr_next;
            good_reg      <= good_next;
            xrange_reg    <= xrange_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        xoff_reg <= xoff_next;
        rsp_reg  <= rsp_next;
    end

    // Next state, RAM accesses and response
    always_comb
    begin
        state_next     = state_reg;
        lcount_next    = lcount_reg;
        usable_next    = usable_reg;
        blk_next       = blk_reg;
        ptr_next       = ptr_reg;
        good_next      = good_reg;
        xoff_next      = xoff_reg;
        xrange_next    = xrange_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        list_we    = 1'b0;
        list_waddr = lcount_reg[LI_W-1:0];
        list_wdata = req.locked_block;
        list_raddr = ptr_reg[LI_W-1:0];
        map_we     = 1'b0;
        map_waddr  = good_reg[BLK_W-1:0];
        map_wdata  = blk_reg;
        map_raddr  = BLK_W'(vblk);

        req_stall  = !((state_reg == ST_IDLE) && out_free);

        unique case (state_reg)
            ST_IDLE:
            begin
                // first list entry is fetched ahead of a build
                list_raddr = '0;
                if (req_valid && out_free)
                begin
                    rsp_next.physical_address = '0;
                    rsp_next.good_count       = GOOD_W'(usable_reg);
                    case (req.mode)
                        MODE_APPEND:
                        begin
                            rsp_valid_next = 1'b1;
                            if (lcount_reg < LC_W'(LOCKED_MAX))
                            begin
                                list_we         = 1'b1;
                                lcount_next     = lcount_reg + 1'b1;
                                rsp_next.status = STAT_OK;
                            end
                            else
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                        end
                        MODE_BUILD:
                        begin
                            if (req.header_word == HEADER_MAGIC)
                            begin
                                state_next = ST_BUILD;
                                blk_next   = '0;
                                ptr_next   = '0;
                                good_next  = '0;
                            end
                            else
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = STAT_BAD_MAGIC;
                            end
                        end
                        MODE_XLATE:
                        begin
                            state_next  = ST_XLATE;
                            xoff_next   = voff;
                            xrange_next = VC_W'(vblk) >= VC_W'(usable_reg);
                        end
                        default:
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end
            end

            ST_BUILD:
            begin
                // one physical block per cycle; skip it if it is the current list entry
                if (match)
                begin
                    ptr_next   = ptr_inc;
                    list_raddr = ptr_inc[LI_W-1:0];
                end
                else
                begin
                    map_we    = 1'b1;
                    good_next = good_inc;
                end
                if (blk_reg == BLK_W'(BLOCK_COUNT - 1))
                begin
                    usable_next    = good_next;
                    state_next     = ST_IDLE;
                    ptr_next       = '0;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STAT_OK, physical_address: '0,
                                       good_count: GOOD_W'(good_next)};
                end
                else
                begin
                    blk_next = blk_reg + 1'b1;
                end
            end

            ST_XLATE:
            begin
                // table data is back; rejoin block and offset, or answer STAT_RANGE when out of range
                state_next              = ST_IDLE;
                rsp_valid_next          = 1'b1;
                rsp_next.good_count     = GOOD_W'(usable_reg);
                if (xrange_reg)
                begin
                    rsp_next.status           = STAT_RANGE;
                    rsp_next.physical_address = '0;
                end
                else
                begin
                    rsp_next.status           = STAT_OK;
                    rsp_next.physical_address = phys_wide[ADDR_W-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/bad_block_skip_translation_core.sv]
// An append, an unused mode or a build with a wrong header answers in the cycle after
// acceptance, a translation after one remap-table read, a build with the right header
// after walking every block (one block per cycle).
// Only one word is in work at a time.
// Reset (rst_n, async, active low) empties the locked list and the good-block count;
// both RAMs hold undefined data until written.
module bad_block_skip_translation_core
    import bbst_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LOCKED_MAX  = LOCKED_MAX_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int BLK_W = $clog2(BLOCK_COUNT);
    localparam int LI_W  = (LOCKED_MAX > 1) ? $clog2(LOCKED_MAX) : 1;

    logic              list_we;
    logic [LI_W-1:0]   list_waddr;
    logic [LBLK_W-1:0] list_wdata;
    logic [LI_W-1:0]   list_raddr;
    logic [LBLK_W-1:0] list_rdata;
    logic              map_we;
    logic [BLK_W-1:0]  map_waddr;
    logic [BLK_W-1:0]  map_wdata;
    logic [BLK_W-1:0]  map_raddr;
    logic [BLK_W-1:0]  map_rdata;

    // Sequencer
    bbst_ctrl #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .OFFSET_BITS (OFFSET_BITS),
        .LOCKED_MAX  (LOCKED_MAX)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .list_we    (list_we),
        .list_waddr (list_waddr),
        .list_wdata (list_wdata),
        .list_raddr (list_raddr),
        .list_rdata (list_rdata),
        .map_we     (map_we),
        .map_waddr  (map_waddr),
        .map_wdata  (map_wdata),
        .map_raddr  (map_raddr),
        .map_rdata  (map_rdata)
    );

    // Locked block list
    bbst_ram #(
        .WIDTH (LBLK_W),
        .DEPTH (LOCKED_MAX)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // Virtual-to-physical block table
    bbst_ram #(
        .WIDTH (BLK_W),
        .DEPTH (BLOCK_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

endmodule

[tb/bbst_checker.sv]
// Checker for the bad-block skip translation core. It watches both channels, predicts each
// answer from its own locked list and remap table, and counts mismatches for the top.
// Depends on bbst_pkg for the word types, field widths and status codes.
`timescale 1ns / 1ps
module bbst_checker
    import bbst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);

    localparam int VBLK_W     = ADDR_W - OFFSET_BITS_DEF;
    localparam int REPORT_MAX = 10;

    // Shadow of the block's state
    logic [LBLK_W-1:0] lock_list [LOCKED_MAX_DEF];
    int                list_len = 0;
    logic [LBLK_W-1:0] remap [BLOCK_COUNT_DEF];
    logic [GOOD_W-1:0] usable = '0;

    rsp_t answers_due [$];
    int   bad_count  = 0;
    int   answer_idx = 0;

    // Answer to one request word; updates the shadow state
    function automatic rsp_t answer_for(input req_t w);
        rsp_t              a;
        int                ptr;
        int                good;
        int                blk;
        logic [VBLK_W-1:0] vblk;
        a = '0;
        case (w.mode)
            MODE_APPEND:
            begin
                if (list_len < LOCKED_MAX_DEF)
                begin
                    lock_list[list_len] = w.locked_block;
                    list_len++;
                end
                else
                    a.status = STAT_FULL;
            end
            MODE_BUILD:
            begin
                if (w.header_word != HEADER_MAGIC)
                    a.status = STAT_BAD_MAGIC;
                else
                begin
                    // walk every block, skipping the one the list pointer names
                    ptr  = 0;
                    good = 0;
                    for (blk = 0; blk < BLOCK_COUNT_DEF; blk++)
                    begin
                        if (ptr < list_len && lock_list[ptr] == blk[LBLK_W-1:0])
                            ptr++;
                        else
                        begin
                            remap[good] = blk[LBLK_W-1:0];
                            good++;
                        end
                    end
                    usable = good[GOOD_W-1:0];
                end
            end
            MODE_XLATE:
            begin
                vblk = w.vaddr[ADDR_W-1:OFFSET_BITS_DEF];
                if ({1'b0, vblk} >= usable)
                    a.status = STAT_RANGE;
                else
                    a.physical_address = {remap[vblk],
                                          w.vaddr[OFFSET_BITS_DEF-1:0]};
            end
            default: ;  // unused mode: no change, zero status and address
        endcase
        a.good_count = usable;
        return a;
    endfunction

    // Compare answers first, then predict the word taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t due;
        if (!rst_n)
        begin
            answers_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    if (bad_count < REPORT_MAX)
                        $display("answer %0d arrived with nothing due: status %0d addr %h good %0d",
                                 answer_idx, rsp.status, rsp.physical_address, rsp.good_count);
                    bad_count++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (rsp.status !== due.status
                        || rsp.physical_address !== due.physical_address
                        || rsp.good_count !== due.good_count)
                    begin
                        if (bad_count < REPORT_MAX)
                        begin
                            $display("answer %0d: expected status %0d addr %h good %0d",
                                     answer_idx, due.status, due.physical_address,
                                     due.good_count);
                            $display("answer %0d:      got status %0d addr %h good %0d",
                                     answer_idx, rsp.status, rsp.physical_address,
                                     rsp.good_count);
                        end
                        bad_count++;
                    end
                end
                answer_idx++;
            end
            if (req_valid && !req_stall)
                answers_due.push_back(answer_for(req));
            errors  <= bad_count;
            pending <= answers_due.size();
        end
    end

endmodule

[tb/tb_bad_block_skip_translation_core.sv]
// Testbench top for bad_block_skip_translation_core: clock, reset, directed and random
// request words, receiver stalls, and the verdict. Needs bbst_pkg and bbst_checker.
`timescale 1ns / 1ps
module tb_bad_block_skip_translation_core;
    import bbst_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int LIMIT_CYCLES   = 1_500_000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = BLOCK_COUNT_DEF + 64;
    localparam int RAND_PER_PHASE = 340;
    localparam int VBLK_W         = ADDR_W - OFFSET_BITS_DEF;

    // mode 3 has no meaning in the block
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   errors;
    int   pending;

    // Pacing
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asks   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    // Stimulus bookkeeping: list length, last ascending entry, entries the walk will skip
    int list_len  = 0;
    int last_lock = -1;
    int walk_hits = 0;
    int good_now  = 0;

    int n_append  = 0;
    int n_refused = 0;
    int n_build   = 0;
    int n_xlate   = 0;
    int n_unused  = 0;

    bad_block_skip_translation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bbst_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always #CLK_HALF clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d answers still due", cycle_count, pending);
            $display("FAIL bad_block_skip_translation_core");
            $finish;
        end
    end

    // Receiver: one long hold-off per request, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Offer one word, with random idle cycles ahead of it, and wait until it is taken
    task automatic send_word(input req_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do @(posedge clk); while (req_stall);
    endtask

    // Stop offering and wait until every answer has come back
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Unused mode with random content in every field
    function automatic req_t noise_word();
        req_t w;
        w.mode         = MODE_UNUSED;
        w.locked_block = LBLK_W'($urandom);
        w.header_word  = $urandom;
        w.vaddr        = ADDR_W'($urandom);
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] join_addr(input int vblk, input int offs);
        return {VBLK_W'(vblk), OFFSET_BITS_DEF'(offs)};
    endfunction

    task automatic append_block(input logic [LBLK_W-1:0] blk);
        req_t w;
        w              = noise_word();
        w.mode         = MODE_APPEND;
        w.locked_block = blk;
        send_word(w);
        n_append++;
        if (list_len < LOCKED_MAX_DEF)
            list_len++;
        else
            n_refused++;
    endtask

    // Next ascending entry; the gap leaves room for a full list below the last block
    task automatic append_next();
        int left;
        int room;
        left      = LOCKED_MAX_DEF - 1 - list_len;
        room      = BLOCK_COUNT_DEF - 1 - last_lock - left;
        last_lock = last_lock + 1 + $urandom_range(0, room < 3 ? room : 3);
        walk_hits++;
        append_block(LBLK_W'(last_lock));
    endtask

    task automatic build_table(input logic [HDR_W-1:0] hdr);
        req_t w;
        w             = noise_word();
        w.mode        = MODE_BUILD;
        w.header_word = hdr;
        send_word(w);
        n_build++;
        if (hdr == HEADER_MAGIC)
            good_now = BLOCK_COUNT_DEF - walk_hits;
    endtask

    task automatic translate(input logic [ADDR_W-1:0] va);
        req_t w;
        w       = noise_word();
        w.mode  = MODE_XLATE;
        w.vaddr = va;
        send_word(w);
        n_xlate++;
    endtask

    // Mostly in-range virtual blocks, the rest anywhere in the address space
    task automatic translate_random();
        if (good_now != 0 && $urandom_range(0, 99) < 85)
            translate(join_addr($urandom_range(0, good_now - 1), $urandom));
        else
            translate(ADDR_W'($urandom));
    endtask

    // Ascending list growth with periodic builds and lookups, plus some noise
    task automatic random_traffic(input int count);
        int               pick;
        logic [HDR_W-1:0] hdr;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if (list_len < LOCKED_MAX_DEF - 1)
                    append_next();
                else
                    translate_random();
            end
            else if (pick < 38)
                build_table(HEADER_MAGIC);
            else if (pick < 40)
            begin
                hdr = $urandom;
                if (hdr == HEADER_MAGIC)
                    hdr = ~hdr;
                build_table(hdr);
            end
            else if (pick < 43)
            begin
                send_word(noise_word());
                n_unused++;
            end
            else
                translate_random();
        end
    endtask

    initial
    begin
        req_t w;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lookups before any table, unused mode, wrong and right magic
        translate('0);
        translate('1);
        w = '1;
        send_word(w);
        n_unused++;
        build_table('0);
        build_table('1);
        build_table(HEADER_MAGIC ^ 32'h1);
        // empty list: every block usable, identity mapping
        build_table(HEADER_MAGIC);
        translate('0);
        translate('1);
        translate(join_addr(0, '1));
        append_block(LBLK_W'(0));
        append_block(LBLK_W'(1));
        append_block(LBLK_W'(3));
        last_lock = 3;
        walk_hits = 3;
        // wrong magic keeps the old table
        build_table('0);
        translate('1);
        build_table(HEADER_MAGIC);
        translate(join_addr(0, $urandom));
        translate(join_addr(BLOCK_COUNT_DEF - 4, $urandom));
        translate(join_addr(BLOCK_COUNT_DEF - 3, $urandom));
        w      = '0;
        w.mode = MODE_UNUSED;
        send_word(w);
        n_unused++;
        drain();

        // Sender idles lightly, receiver heavily, with one long hold-off at the start
        tx_idle_pct = 20;
        rx_idle_pct <= 57;
        hold_asks   <= hold_asks + 1;
        random_traffic(RAND_PER_PHASE);
        drain();

        // Roles swapped
        tx_idle_pct = 57;
        rx_idle_pct <= 20;
        random_traffic(RAND_PER_PHASE);
        drain();

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_traffic(RAND_PER_PHASE);

        // Close the list with a repeated entry; the walk never reaches what follows it
        append_block(LBLK_W'(last_lock));
        repeat (6) append_block(LBLK_W'($urandom));
        build_table(HEADER_MAGIC);
        translate(join_addr(good_now - 1, $urandom));
        translate(join_addr(good_now, $urandom));
        repeat (60) translate_random();
        build_table(HEADER_MAGIC ^ 32'h8000_0000);
        send_word(noise_word());
        n_unused++;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d words: %0d appends (%0d on a full list), %0d builds, %0d translations",
                 n_append + n_build + n_xlate + n_unused, n_append, n_refused, n_build,
                 n_xlate);
        $display("%0d unused-mode words; list ended at %0d entries, %0d usable blocks",
                 n_unused, list_len, good_now);
        if (errors == 0)
            $display("PASS bad_block_skip_translation_core");
        else
            $display("FAIL bad_block_skip_translation_core");
        $finish;
    end

endmodule

[filelist.f]
design/bbst_pkg.sv
design/bbst_ram.sv
design/bbst_ctrl.sv
design/bad_block_skip_translation_core.sv
tb/bbst_checker.sv
tb/tb_bad_block_skip_translation_core.sv
